>>> src/periodic_alarm_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic alarm scheduler
// Implication checks on a clock with a synchronous reset that disables them.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_ALARM_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_ALARM_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define PAS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PAS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/pas_pkg.sv
// ----------------------------------------------------------------------------
// pas_pkg
// Types and constants shared by the periodic alarm scheduler modules.
// ----------------------------------------------------------------------------
package pas_pkg;

   localparam int SLOTS       = 16;
   localparam int MAX_FIRES   = 64;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(MAX_FIRES + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRED  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [7:0]  task_id;
      logic        task_present;
      logic [31:0] notify_bits;
      logic [31:0] initial_delay;
      logic [31:0] period;
      logic [31:0] current_time;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [7:0]  fired_task;
      logic        fired_task_present;
      logic [31:0] fired_mask;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_REJECT,
      CMD_TICK
   } cmd_kind_type;

   // value holds the first due time for an insert and the current time for a tick
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   task_id;
      logic         task_present;
      logic [31:0]  notify_bits;
      logic [31:0]  value;
      logic [31:0]  period;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

>>> src/pas_front.sv
// ----------------------------------------------------------------------------
// pas_front
// Accepts requests, classifies them and computes the first due time.
// ----------------------------------------------------------------------------
module pas_front (
   input  logic                    start,
   output logic                    busy,
   input  pas_pkg::req_type        req_data,
   input  pas_pkg::queue_stat_type q_stat,
   output logic                    push,
   output pas_pkg::cmd_type        push_cmd
);

   assign busy = q_stat.full;
   assign push = start && !q_stat.full;

   always_comb begin
      push_cmd              = '0;
      push_cmd.task_id      = req_data.task_id;
      push_cmd.task_present = req_data.task_present;
      push_cmd.notify_bits  = req_data.notify_bits;
      push_cmd.period       = req_data.period;
      if (req_data.operation == pas_pkg::OP_TICK) begin
         push_cmd.kind  = pas_pkg::CMD_TICK;
         push_cmd.value = req_data.current_time;
      end else begin
         // wrap modulo 2^32
         push_cmd.value = req_data.initial_delay + req_data.period;
         if (req_data.period == 32'd0) begin
            push_cmd.kind = pas_pkg::CMD_REJECT;
         end else begin
            push_cmd.kind = pas_pkg::CMD_INSERT;
         end
      end
   end

endmodule

>>> src/pas_queue.sv
// ----------------------------------------------------------------------------
// pas_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module pas_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pas_pkg::cmd_type        push_cmd,
   input  logic                    pop,
   output pas_pkg::cmd_type        pop_cmd,
   output pas_pkg::queue_stat_type q_stat
);

   pas_pkg::cmd_type                 entry_ff [pas_pkg::QUEUE_DEPTH];
   logic [pas_pkg::QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pas_pkg::QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pas_pkg::QUEUE_CW-1:0]     count_ff, count_in;
   logic                             do_push, do_pop;

   assign q_stat.full  = (count_ff == pas_pkg::QUEUE_CW'(pas_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_cmd      = entry_ff[rd_ptr_ff];

   assign do_push = push && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == pas_pkg::QUEUE_AW'(pas_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == pas_pkg::QUEUE_AW'(pas_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/pas_back.sv
// ----------------------------------------------------------------------------
// pas_back
// Executes queued commands against the alarm table: slot scan, insert, fire.
// ----------------------------------------------------------------------------
`include "periodic_alarm_scheduler_unit_macros.svh"

module pas_back (
   input  logic                    clock,
   input  logic                    reset,
   input  pas_pkg::queue_stat_type q_stat,
   input  pas_pkg::cmd_type        pop_cmd,
   output logic                    pop,
   output logic                    rsp_strobe,
   output pas_pkg::rsp_type        rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_READ,
      ST_FIRE,
      ST_FLUSH
   } state_type;

   localparam logic [pas_pkg::SLOT_W-1:0] LAST_SLOT = pas_pkg::SLOT_W'(pas_pkg::SLOTS - 1);
   localparam logic [pas_pkg::CNT_W-1:0]  LAST_FIRE = pas_pkg::CNT_W'(pas_pkg::MAX_FIRES - 1);

   state_type                    state_ff, state_in;
   pas_pkg::cmd_type             cmd_ff, cmd_in;
   logic [pas_pkg::SLOT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic                         issue_ff, issue_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [pas_pkg::SLOT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                         rd_last_ff, rd_last_in;
   logic                         best_vld_ff, best_vld_in;
   logic [pas_pkg::SLOT_W-1:0]   best_idx_ff, best_idx_in;
   logic [31:0]                  best_due_ff, best_due_in;
   logic                         pend_vld_ff, pend_vld_in;
   pas_pkg::rsp_type             pend_ff, pend_in;
   logic [pas_pkg::CNT_W-1:0]    fire_cnt_ff, fire_cnt_in;
   logic [pas_pkg::SLOTS-1:0]    valid_ff, valid_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   pas_pkg::rsp_type             rsp_ff, rsp_in;

   // table storage, read through registers
   logic [31:0] due_mem_ff  [pas_pkg::SLOTS];
   logic [31:0] per_mem_ff  [pas_pkg::SLOTS];
   logic [7:0]  task_mem_ff [pas_pkg::SLOTS];
   logic        pres_mem_ff [pas_pkg::SLOTS];
   logic [31:0] mask_mem_ff [pas_pkg::SLOTS];
   logic [31:0] rd_due_ff;
   logic        rd_slot_vld_ff;
   logic [31:0] fire_per_ff;
   logic [7:0]  fire_task_ff;
   logic        fire_pres_ff;
   logic [31:0] fire_mask_ff;
   logic        slot_we, due_we;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      scan_idx_in   = scan_idx_ff;
      issue_in      = issue_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = scan_idx_ff;
      rd_last_in    = 1'b0;
      best_vld_in   = best_vld_ff;
      best_idx_in   = best_idx_ff;
      best_due_in   = best_due_ff;
      pend_vld_in   = pend_vld_ff;
      pend_in       = pend_ff;
      fire_cnt_in   = fire_cnt_ff;
      valid_in      = valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      slot_we       = 1'b0;
      due_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            fire_cnt_in = '0;
            if (!q_stat.empty) begin
               pop    = 1'b1;
               cmd_in = pop_cmd;
               case (pop_cmd.kind)
                  pas_pkg::CMD_REJECT: begin
                     rsp_strobe_in  = 1'b1;
                     rsp_in         = '0;
                     rsp_in.kind    = pas_pkg::KIND_STATUS;
                     rsp_in.status  = pas_pkg::STATUS_INVALID;
                     rsp_in.last    = 1'b1;
                  end
                  pas_pkg::CMD_INSERT, pas_pkg::CMD_TICK: begin
                     state_in    = ST_SCAN;
                     scan_idx_in = '0;
                     issue_in    = 1'b1;
                     best_vld_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (issue_ff) begin
               rd_vld_in  = 1'b1;
               rd_last_in = (scan_idx_ff == LAST_SLOT);
               if (scan_idx_ff == LAST_SLOT) begin
                  issue_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
            if (rd_vld_ff) begin
               if (cmd_ff.kind == pas_pkg::CMD_INSERT) begin
                  // lowest free slot
                  if (!rd_slot_vld_ff && !best_vld_ff) begin
                     best_vld_in = 1'b1;
                     best_idx_in = rd_idx_ff;
                  end
               end else begin
                  // strict compare keeps the lowest slot on ties
                  if (rd_slot_vld_ff && (!best_vld_ff || (rd_due_ff < best_due_ff))) begin
                     best_vld_in = 1'b1;
                     best_idx_in = rd_idx_ff;
                     best_due_in = rd_due_ff;
                  end
               end
               if (rd_last_ff) begin
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_DECIDE: begin
            case (cmd_ff.kind)
               pas_pkg::CMD_INSERT: begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
                  rsp_in.kind   = pas_pkg::KIND_STATUS;
                  rsp_in.last   = 1'b1;
                  if (best_vld_ff) begin
                     slot_we               = 1'b1;
                     valid_in[best_idx_ff] = 1'b1;
                     rsp_in.status         = pas_pkg::STATUS_OK;
                  end else begin
                     rsp_in.status = pas_pkg::STATUS_FULL;
                  end
                  state_in = ST_IDLE;
               end
               pas_pkg::CMD_TICK: begin
                  if (best_vld_ff && (cmd_ff.value >= best_due_ff)) begin
                     state_in = ST_READ;
                  end else begin
                     // nothing more is due: release the held record as the last one
                     if (pend_vld_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in        = pend_ff;
                        rsp_in.last   = 1'b1;
                     end
                     pend_vld_in = 1'b0;
                     state_in    = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_READ: begin
            state_in = ST_FIRE;
         end

         ST_FIRE: begin
            // hold the new record until we know whether another follows
            if (pend_vld_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b0;
            end
            pend_vld_in                = 1'b1;
            pend_in                    = '0;
            pend_in.kind               = pas_pkg::KIND_FIRED;
            pend_in.status             = pas_pkg::STATUS_OK;
            pend_in.fired_task         = fire_task_ff;
            pend_in.fired_task_present = fire_pres_ff;
            pend_in.fired_mask         = fire_mask_ff;
            due_we                     = 1'b1;
            fire_cnt_in                = fire_cnt_ff + 1'b1;
            if (fire_cnt_ff == LAST_FIRE) begin
               state_in = ST_FLUSH;
            end else begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
               issue_in    = 1'b1;
               best_vld_in = 1'b0;
            end
         end

         ST_FLUSH: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = pend_ff;
            rsp_in.last   = 1'b1;
            pend_vld_in   = 1'b0;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         best_vld_ff   <= 1'b0;
         pend_vld_ff   <= 1'b0;
         fire_cnt_ff   <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         rd_vld_ff     <= rd_vld_in;
         rd_last_ff    <= rd_last_in;
         best_vld_ff   <= best_vld_in;
         pend_vld_ff   <= pend_vld_in;
         fire_cnt_ff   <= fire_cnt_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff      <= cmd_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_due_ff <= best_due_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      rd_due_ff      <= due_mem_ff[scan_idx_ff];
      rd_slot_vld_ff <= valid_ff[scan_idx_ff];
      fire_per_ff    <= per_mem_ff[best_idx_ff];
      fire_task_ff   <= task_mem_ff[best_idx_ff];
      fire_pres_ff   <= pres_mem_ff[best_idx_ff];
      fire_mask_ff   <= mask_mem_ff[best_idx_ff];
      if (slot_we) begin
         due_mem_ff[best_idx_ff]  <= cmd_ff.value;
         per_mem_ff[best_idx_ff]  <= cmd_ff.period;
         task_mem_ff[best_idx_ff] <= cmd_ff.task_id;
         pres_mem_ff[best_idx_ff] <= cmd_ff.task_present;
         mask_mem_ff[best_idx_ff] <= cmd_ff.notify_bits;
      end else if (due_we) begin
         // advance modulo 2^32
         due_mem_ff[best_idx_ff] <= best_due_ff + fire_per_ff;
      end
   end

   `PAS_ASSERT_IMP(a_status_is_last, clock, reset, rsp_strobe_ff && (rsp_ff.kind == pas_pkg::KIND_STATUS), rsp_ff.last, "insert status without last")
   `PAS_ASSERT_IMP(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, !pend_vld_ff, "fired record held while idle")
   `PAS_ASSERT_IMP(a_fire_limit, clock, reset, state_ff == ST_FIRE, fire_cnt_ff <= LAST_FIRE, "fire count beyond limit")
   `PAS_ASSERT_NXT(a_fire_releases, clock, reset, (state_ff == ST_FIRE) && pend_vld_ff, rsp_strobe_ff && !rsp_ff.last && (rsp_ff.kind == pas_pkg::KIND_FIRED), "held record not released on fire")

endmodule

>>> src/periodic_alarm_scheduler_unit.sv
// ----------------------------------------------------------------------------
// periodic_alarm_scheduler_unit
// Table of periodic alarms with insert and tick requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. An
//   insert (operation 0) answers one status result: ok, invalid period (zero)
//   or table full. A tick (operation 1) answers zero or more fired records,
//   one per alarm firing, earliest due time first, lowest slot on ties, at most
//   MAX_FIRES per tick; the last record carries last = 1. A tick with nothing
//   due answers nothing.
//   Each result is on rsp_data for one cycle with rsp_strobe high; the
//   receiver cannot stall, so results are never held back.
//   An invalid insert answers without a slot scan. A valid insert
//   scans every slot serially (one slot read per cycle). A tick runs
//   scan, compare, table read and fire once per fired alarm, then a
//   final scan that finds nothing due, or a flush state once MAX_FIRES
//   records fired.
//   A two-entry command queue takes further requests while one executes;
//   busy is high while that queue is full.
//   Reset (synchronous) empties the table and the queue.
// ----------------------------------------------------------------------------
module periodic_alarm_scheduler_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pas_pkg::req_type req_data,
   output logic             rsp_strobe,
   output pas_pkg::rsp_type rsp_data
);

   pas_pkg::queue_stat_type q_stat;
   pas_pkg::cmd_type        push_cmd;
   pas_pkg::cmd_type        pop_cmd;
   logic                    push;
   logic                    pop;

   pas_front u_front (
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_stat   (q_stat),
      .push     (push),
      .push_cmd (push_cmd)
   );

   pas_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_stat   (q_stat)
   );

   pas_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop_cmd    (pop_cmd),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends insert and tick requests to the periodic alarm scheduler. It checks
// every result against an alarm table kept in the bench. A table of directed
// requests runs first, then random traffic with bursty request pacing.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SETTLE_CYCLES = 4 * (pas_pkg::SLOTS + 4) + 10;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_ITEMS  = 250;
   localparam int DRAIN_EVERY   = 80;

   typedef struct packed {
      pas_pkg::req_type req;
      logic             typed;
      logic [1:0]       status;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   pas_pkg::req_type req_data;
   logic             rsp_strobe;
   pas_pkg::rsp_type rsp_data;

   // typed expectation that travels with the request
   logic       row_typed;
   logic [1:0] row_status;

   // alarm table copy
   bit          alarm_live   [pas_pkg::SLOTS];
   logic [31:0] alarm_due    [pas_pkg::SLOTS];
   logic [31:0] alarm_period [pas_pkg::SLOTS];
   logic [7:0]  alarm_task   [pas_pkg::SLOTS];
   logic        alarm_flag   [pas_pkg::SLOTS];
   logic [31:0] alarm_mask   [pas_pkg::SLOTS];

   pas_pkg::rsp_type awaited_rsp[$];
   stim_row_type     directed_rows[$];
   int               fail_count;
   int               burst_left;
   logic [31:0]      track_time;

   periodic_alarm_scheduler_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic log_fail(input string msg);
      if (fail_count < REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) log_fail($sformatf("%s expected %h, got %h", name, want, got));
   endtask

   task automatic check_result(input pas_pkg::rsp_type got);
      pas_pkg::rsp_type want;
      if (awaited_rsp.size() == 0) begin
         log_fail($sformatf("result %h with nothing expected", got));
      end else begin
         want = awaited_rsp.pop_front();
         check_field("kind", 32'(want.kind), 32'(got.kind));
         check_field("status", 32'(want.status), 32'(got.status));
         check_field("fired_task", 32'(want.fired_task), 32'(got.fired_task));
         check_field("fired_task_present", 32'(want.fired_task_present),
                     32'(got.fired_task_present));
         check_field("fired_mask", want.fired_mask, got.fired_mask);
         check_field("last", 32'(want.last), 32'(got.last));
      end
   endtask

   // Apply one request to the alarm table and queue the results it causes.
   task automatic step_alarm_table(input pas_pkg::req_type r, input logic typed,
                                   input logic [1:0] st);
      pas_pkg::rsp_type rec;
      pas_pkg::rsp_type held;
      bit               have_held;
      bit               done;
      int               free_slot;
      int               best;
      int               fires;
      rec = '0;
      held = '0;
      if (r.operation == pas_pkg::OP_INSERT) begin
         rec.kind = pas_pkg::KIND_STATUS;
         rec.last = 1'b1;
         free_slot = -1;
         for (int i = pas_pkg::SLOTS - 1; i >= 0; i--)
            if (!alarm_live[i]) free_slot = i;
         if (r.period == '0) begin
            rec.status = pas_pkg::STATUS_INVALID;
         end else if (free_slot < 0) begin
            rec.status = pas_pkg::STATUS_FULL;
         end else begin
            rec.status = pas_pkg::STATUS_OK;
            alarm_live[free_slot]   = 1'b1;
            alarm_due[free_slot]    = r.initial_delay + r.period;
            alarm_period[free_slot] = r.period;
            alarm_task[free_slot]   = r.task_id;
            alarm_flag[free_slot]   = r.task_present;
            alarm_mask[free_slot]   = r.notify_bits;
         end
         if (typed) rec.status = st;
         awaited_rsp.push_back(rec);
      end else begin
         fires = 0;
         done = 1'b0;
         have_held = 1'b0;
         while (!done && fires < pas_pkg::MAX_FIRES) begin
            best = -1;
            for (int i = 0; i < pas_pkg::SLOTS; i++)
               if (alarm_live[i] && (best < 0 || alarm_due[i] < alarm_due[best])) best = i;
            if (best < 0 || r.current_time < alarm_due[best]) begin
               done = 1'b1;
            end else begin
               // hold back the newest record so the final one can carry last
               if (have_held) awaited_rsp.push_back(held);
               held = '0;
               held.kind = pas_pkg::KIND_FIRED;
               held.status = pas_pkg::STATUS_OK;
               held.fired_task = alarm_task[best];
               held.fired_task_present = alarm_flag[best];
               held.fired_mask = alarm_mask[best];
               have_held = 1'b1;
               alarm_due[best] = alarm_due[best] + alarm_period[best];
               fires++;
            end
         end
         if (have_held) begin
            held.last = 1'b1;
            awaited_rsp.push_back(held);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pas_pkg::SLOTS; i++) alarm_live[i] = 1'b0;
         awaited_rsp.delete();
      end else begin
         if (rsp_strobe) check_result(rsp_data);
         if (start && !busy) step_alarm_table(req_data, row_typed, row_status);
      end
   end

   function automatic pas_pkg::req_type insert_req(input logic [7:0] id,
                                                   input logic flag,
                                                   input logic [31:0] mask,
                                                   input logic [31:0] delay,
                                                   input logic [31:0] period);
      pas_pkg::req_type r;
      r.operation     = pas_pkg::OP_INSERT;
      r.task_id       = id;
      r.task_present  = flag;
      r.notify_bits   = mask;
      r.initial_delay = delay;
      r.period        = period;
      r.current_time  = $urandom;
      return r;
   endfunction

   function automatic pas_pkg::req_type tick_req(input logic [31:0] now);
      pas_pkg::req_type r;
      r.operation     = pas_pkg::OP_TICK;
      r.task_id       = 8'($urandom);
      r.task_present  = 1'($urandom_range(0, 1));
      r.notify_bits   = $urandom;
      r.initial_delay = $urandom;
      r.period        = $urandom;
      r.current_time  = now;
      return r;
   endfunction

   function automatic void add_row(input pas_pkg::req_type r, input logic typed,
                                   input logic [1:0] st);
      stim_row_type row;
      row.req = r;
      row.typed = typed;
      row.status = st;
      directed_rows.push_back(row);
   endfunction

   function automatic void build_directed_rows();
      // empty table: no results
      add_row(tick_req(32'hFFFF_FFFF), 1'b0, pas_pkg::STATUS_OK);
      add_row(insert_req(8'hFF, 1'b1, '1, '1, '0), 1'b1, pas_pkg::STATUS_INVALID);
      add_row(insert_req(8'hFF, 1'b1, '1, 32'd0, 32'd1), 1'b1, pas_pkg::STATUS_OK);
      // first due time wraps around to 1, tying with slot 0
      add_row(insert_req(8'h00, 1'b0, '0, '1, 32'd2), 1'b1, pas_pkg::STATUS_OK);
      add_row(tick_req(32'd0), 1'b0, pas_pkg::STATUS_OK);
      add_row(tick_req(32'd1), 1'b0, pas_pkg::STATUS_OK);
      // deep backlog: the fire limit cuts the tick, the next tick continues
      add_row(tick_req(32'd100), 1'b0, pas_pkg::STATUS_OK);
      add_row(tick_req(32'd100), 1'b0, pas_pkg::STATUS_OK);
      add_row(insert_req(8'h5A, 1'b1, 32'hA5A5_5A5A, '1, '1), 1'b1, pas_pkg::STATUS_OK);
      for (int i = 0; i < pas_pkg::SLOTS - 3; i++)
         add_row(insert_req(8'(8'h10 + i), 1'(i), 32'h0F0F_0000 ^ (32'h1 << i),
                            32'd100, 32'(3 + 5 * i)), 1'b1, pas_pkg::STATUS_OK);
      add_row(insert_req(8'hC3, 1'b0, 32'h1234_5678, 32'd7, 32'd9), 1'b1,
              pas_pkg::STATUS_FULL);
   endfunction

   // Mostly ticks that walk time forward; some inserts and far-off tick times.
   function automatic pas_pkg::req_type random_req();
      pas_pkg::req_type r;
      int               roll;
      r = tick_req($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         r.operation = pas_pkg::OP_INSERT;
         if ($urandom_range(0, 2) == 0) r.period = '0;
      end else if (roll >= 17) begin
         track_time = track_time + $urandom_range(0, 40);
         r.current_time = track_time;
      end
      return r;
   endfunction

   task automatic issue(input pas_pkg::req_type r, input logic typed,
                        input logic [1:0] st);
      req_data   <= r;
      row_typed  <= typed;
      row_status <= st;
      start      <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0);
   endtask

   initial begin
      stim_row_type row;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      row_typed  = 1'b0;
      row_status = pas_pkg::STATUS_OK;
      fail_count = 0;
      burst_left = 0;
      track_time = 32'd100;
      build_directed_rows();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         issue(row.req, row.typed, row.status);
         pace();
      end
      drain();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         issue(random_req(), 1'b0, pas_pkg::STATUS_OK);
         if (n % DRAIN_EVERY == DRAIN_EVERY - 1) drain();
         else pace();
      end
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/pas_pkg.sv
src/pas_front.sv
src/pas_queue.sv
src/pas_back.sv
src/periodic_alarm_scheduler_unit.sv
dv/testbench.sv
